>>> rtl/ray_sphere_intersection_macros.svh
// Assertion macros used by the ray-sphere intersection queue (rsi_fifo)
`ifndef RAY_SPHERE_INTERSECTION_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");
`define RSI_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define RSI_ASSERT(lbl, clk, rst_n, prop)
`define RSI_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/rsi_pkg.sv
// Types and constants shared by the ray-sphere intersection modules
`timescale 1ns / 1ps
package rsi_pkg;

    localparam int W_C       = 32;
    localparam int W_RAD     = 31;
    localparam int W_MIN     = 17;
    localparam int W_V       = W_C + 1;
    localparam int W_A       = 67;
    localparam int W_D2      = 64;
    localparam int W_E       = 67;
    localparam int W_DELTA   = 132;
    localparam int W_ROOT    = W_DELTA / 2;
    localparam int W_NUM     = 68;
    localparam int W_MAG     = W_NUM - 1;
    localparam int W_T       = 32;
    localparam int DIV_LAT   = W_T + 3;
    localparam int Q_DEPTH   = 4;
    localparam int W_QPTR    = 2;
    localparam int W_CFG_IDX = 3;

    localparam logic [W_CFG_IDX-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_MIN_DIST = 3'd4;

    localparam logic [W_RAD-1:0] RADIUS_RESET = 31'd65536;
    localparam logic [W_MIN-1:0] MIN_RESET    = 17'd66;

    localparam logic [W_T-1:0] T_MAX = {1'b0, {(W_T-1){1'b1}}};
    localparam logic [W_T-1:0] T_MIN = {1'b1, {(W_T-1){1'b0}}};

    typedef struct packed {
        logic                      hit;
        logic signed [W_NUM-1:0]   neg_a;
        logic [W_DELTA-1:0]        delta;
        logic [W_D2-1:0]           d2;
    } t_front_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic                    hit;
        logic signed [W_T-1:0]   first_t;
        logic                    near_valid;
        logic signed [W_T-1:0]   near_t;
        logic                    far_valid;
        logic signed [W_T-1:0]   far_t;
    } t_result;

endpackage

>>> rtl/ray_sphere_intersection.sv
// Top level of the ray-sphere intersection engine
//
// Input channel (i_valid/o_ready) takes one ray per item: origin and direction,
// signed fixed point. Output channel (o_valid/i_ready) gives one result item per
// ray, in order: hit flag, first-hit distance, near and far roots with flags.
// Sphere centre, radius and minimum distance come in over the write port
// (i_cfg_wr_en, i_cfg_index, i_cfg_wdata); the user must write them only while the
// engine is idle, which the block itself does not enforce. Throughput: one ray
// per clock while o_ready is high. A ray passes the 6-stage front end, the queue,
// the 66-stage square root (one root bit per stage), the root-sum register, the
// 35-stage dividers (one quotient bit per stage) and the output buffer.
// A 4-entry queue parts front and back; a 2-entry output buffer holds finished
// items. When the receiver stalls the back end freezes once the buffer is full,
// the queue fills, and then o_ready drops; no item is lost.
// Reset clears all pipeline valids, the queue and the buffer, and loads the
// registers with centre 0, radius 1.0 and minimum distance 66.
`timescale 1ns / 1ps
module ray_sphere_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [rsi_pkg::W_C-1:0]     i_origin_x,
    input  logic signed [rsi_pkg::W_C-1:0]     i_origin_y,
    input  logic signed [rsi_pkg::W_C-1:0]     i_origin_z,
    input  logic signed [rsi_pkg::W_C-1:0]     i_dir_x,
    input  logic signed [rsi_pkg::W_C-1:0]     i_dir_y,
    input  logic signed [rsi_pkg::W_C-1:0]     i_dir_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_hit,
    output logic signed [rsi_pkg::W_T-1:0]     o_first_t,
    output logic                               o_near_valid,
    output logic signed [rsi_pkg::W_T-1:0]     o_near_t,
    output logic                               o_far_valid,
    output logic signed [rsi_pkg::W_T-1:0]     o_far_t,
    input  logic                               i_cfg_wr_en,
    input  logic [rsi_pkg::W_CFG_IDX-1:0]      i_cfg_index,
    input  logic [rsi_pkg::W_C-1:0]            i_cfg_wdata
);
    import rsi_pkg::*;

    logic signed [W_C-1:0] r_center_x;
    logic signed [W_C-1:0] r_center_y;
    logic signed [W_C-1:0] r_center_z;
    logic [W_RAD-1:0]      r_radius;
    logic [W_MIN-1:0]      r_min_dist;

    t_q_stat     w_q_stat;
    t_front_item w_push_item;
    t_front_item w_pop_item;
    logic        w_push;
    logic        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= RADIUS_RESET;
            r_min_dist <= MIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_wdata;
                CFG_CENTER_Y: r_center_y <= i_cfg_wdata;
                CFG_CENTER_Z: r_center_z <= i_cfg_wdata;
                CFG_RADIUS:   r_radius   <= i_cfg_wdata[W_RAD-1:0];
                CFG_MIN_DIST: r_min_dist <= i_cfg_wdata[W_MIN-1:0];
                default: ;
            endcase
        end
    end

    rsi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_radius   (r_radius),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    rsi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_stat  (w_q_stat)
    );

    rsi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (w_pop_item),
        .i_q_stat       (w_q_stat),
        .o_pop          (w_pop),
        .i_min_distance (r_min_dist),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_first_t      (o_first_t),
        .o_near_valid   (o_near_valid),
        .o_near_t       (o_near_t),
        .o_far_valid    (o_far_valid),
        .o_far_t        (o_far_t)
    );

endmodule

>>> rtl/rsi_front.sv
// Front pipeline: ray setup, dot products and discriminant
`timescale 1ns / 1ps
module rsi_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [rsi_pkg::W_C-1:0] i_origin_x,
    input  logic signed [rsi_pkg::W_C-1:0] i_origin_y,
    input  logic signed [rsi_pkg::W_C-1:0] i_origin_z,
    input  logic signed [rsi_pkg::W_C-1:0] i_dir_x,
    input  logic signed [rsi_pkg::W_C-1:0] i_dir_y,
    input  logic signed [rsi_pkg::W_C-1:0] i_dir_z,
    input  logic signed [rsi_pkg::W_C-1:0] i_center_x,
    input  logic signed [rsi_pkg::W_C-1:0] i_center_y,
    input  logic signed [rsi_pkg::W_C-1:0] i_center_z,
    input  logic [rsi_pkg::W_RAD-1:0]      i_radius,
    input  rsi_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output rsi_pkg::t_front_item           o_item
);
    import rsi_pkg::*;

    localparam int W_DV  = W_V + W_C;
    localparam int W_DD  = 2 * W_C;
    localparam int W_VV  = 2 * W_C + 1;
    localparam int W_R2  = 2 * W_RAD;
    localparam int SPL_A = 33;
    localparam int SPL_D = 32;
    localparam int W_PP  = 68;
    localparam int W_LL  = 2 * SPL_A;

    logic w_adv;
    logic signed [W_C-1:0] w_org [3];
    logic signed [W_C-1:0] w_dir [3];
    logic signed [W_C-1:0] w_cen [3];

    assign w_adv   = !i_q_stat.full;
    assign o_ready = w_adv;

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;
    assign w_cen[0] = i_center_x;
    assign w_cen[1] = i_center_y;
    assign w_cen[2] = i_center_z;

    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6;

    logic signed [W_V-1:0]  r_v1 [3];
    logic signed [W_C-1:0]  r_d1 [3];
    logic [W_RAD-1:0]       r_rad1;

    logic signed [W_DV-1:0] r_dv2 [3];
    logic [W_DD-1:0]        r_dd2 [3];
    logic [W_VV-1:0]        r_vv2 [3];
    logic [W_R2-1:0]        r_r22;

    logic signed [W_A-1:0]  r_a3;
    logic [W_D2-1:0]        r_d23;
    logic signed [W_E-1:0]  r_e3;

    logic [W_LL-1:0]        r_pll4;
    logic signed [W_PP-1:0] r_plh4;
    logic signed [W_PP-1:0] r_phh4;
    logic [2*SPL_D-1:0]     r_qll4;
    logic signed [W_PP-1:0] r_qlh4;
    logic [2*SPL_D-1:0]     r_qhl4;
    logic signed [W_PP-1:0] r_qhh4;
    logic signed [W_A-1:0]  r_a4;
    logic [W_D2-1:0]        r_d24;

    logic [W_DELTA-1:0]     r_aa5;
    logic [W_DELTA-1:0]     r_pd5;
    logic signed [W_A-1:0]  r_a5;
    logic [W_D2-1:0]        r_d25;

    t_front_item            r_item6;

    logic [W_DELTA-1:0]     w_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (w_adv) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_v1[i]  <= {w_org[i][W_C-1], w_org[i]} - {w_cen[i][W_C-1], w_cen[i]};
                r_d1[i]  <= w_dir[i];
                r_dv2[i] <= r_d1[i] * r_v1[i];
                r_dd2[i] <= r_d1[i] * r_d1[i];
                r_vv2[i] <= r_v1[i] * r_v1[i];
            end
            r_rad1 <= i_radius;
            r_r22  <= r_rad1 * r_rad1;

            r_a3  <= {{(W_A-W_DV){r_dv2[0][W_DV-1]}}, r_dv2[0]}
                   + {{(W_A-W_DV){r_dv2[1][W_DV-1]}}, r_dv2[1]}
                   + {{(W_A-W_DV){r_dv2[2][W_DV-1]}}, r_dv2[2]};
            r_d23 <= r_dd2[0] + r_dd2[1] + r_dd2[2];
            r_e3  <= {{(W_E-W_VV){1'b0}}, r_vv2[0]}
                   + {{(W_E-W_VV){1'b0}}, r_vv2[1]}
                   + {{(W_E-W_VV){1'b0}}, r_vv2[2]}
                   - {{(W_E-W_R2){1'b0}}, r_r22};

            r_pll4 <= r_a3[SPL_A-1:0] * r_a3[SPL_A-1:0];
            r_plh4 <= $signed(r_a3[W_A-1:SPL_A]) * $signed({1'b0, r_a3[SPL_A-1:0]});
            r_phh4 <= $signed(r_a3[W_A-1:SPL_A]) * $signed(r_a3[W_A-1:SPL_A]);
            r_qll4 <= r_d23[SPL_D-1:0] * r_e3[SPL_D-1:0];
            r_qlh4 <= $signed({1'b0, r_d23[SPL_D-1:0]}) * $signed(r_e3[W_E-1:SPL_D]);
            r_qhl4 <= r_d23[W_D2-1:SPL_D] * r_e3[SPL_D-1:0];
            r_qhh4 <= $signed({1'b0, r_d23[W_D2-1:SPL_D]}) * $signed(r_e3[W_E-1:SPL_D]);
            r_a4   <= r_a3;
            r_d24  <= r_d23;

            r_aa5 <= ({{(W_DELTA-W_PP){r_phh4[W_PP-1]}}, r_phh4} << (2 * SPL_A))
                   + ({{(W_DELTA-W_PP){r_plh4[W_PP-1]}}, r_plh4} << (SPL_A + 1))
                   + {{(W_DELTA-W_LL){1'b0}}, r_pll4};
            r_pd5 <= {{(W_DELTA-2*SPL_D){1'b0}}, r_qll4}
                   + ({{(W_DELTA-W_PP){r_qlh4[W_PP-1]}}, r_qlh4} << SPL_D)
                   + ({{(W_DELTA-2*SPL_D){1'b0}}, r_qhl4} << SPL_D)
                   + ({{(W_DELTA-W_PP){r_qhh4[W_PP-1]}}, r_qhh4} << (2 * SPL_D));
            r_a5  <= r_a4;
            r_d25 <= r_d24;

            r_item6.hit   <= !w_delta[W_DELTA-1] && (r_d25 != '0);
            r_item6.delta <= w_delta;
            r_item6.neg_a <= -{r_a5[W_A-1], r_a5};
            r_item6.d2    <= r_d25;
        end
    end

    assign w_delta = r_aa5 - r_pd5;

    assign o_push = r_vld6 && w_adv;
    assign o_item = r_item6;

endmodule

>>> rtl/rsi_fifo.sv
// Short item queue between the front and back pipelines
`timescale 1ns / 1ps
`include "ray_sphere_intersection_macros.svh"
module rsi_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rsi_pkg::t_front_item i_item,
    input  logic                 i_pop,
    output rsi_pkg::t_front_item o_item,
    output rsi_pkg::t_q_stat     o_stat
);
    import rsi_pkg::*;

    localparam logic [W_QPTR:0] FULL_CNT = (W_QPTR + 1)'(Q_DEPTH);

    t_front_item       r_mem [Q_DEPTH];
    logic [W_QPTR-1:0] r_wr;
    logic [W_QPTR-1:0] r_rd;
    logic [W_QPTR:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);

    `RSI_NEVER(a_push_when_full, i_clk, i_rst_n, i_push && (r_cnt == FULL_CNT))
    `RSI_NEVER(a_pop_when_empty, i_clk, i_rst_n, i_pop && (r_cnt == '0))
    `RSI_ASSERT(a_cnt_tracks_ptrs, i_clk, i_rst_n, (r_cnt != FULL_CNT) |-> (r_wr - r_rd == r_cnt[W_QPTR-1:0]))

endmodule

>>> rtl/rsi_div.sv
// Pipelined fixed-point root divider with saturation, one quotient bit per stage
`timescale 1ns / 1ps
module rsi_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [rsi_pkg::W_NUM-1:0] i_num,
    input  logic [rsi_pkg::W_D2-1:0]         i_den,
    output logic signed [rsi_pkg::W_T-1:0]   o_t
);
    import rsi_pkg::*;

    localparam int W_SH  = W_MAG + FRAC_BITS;
    localparam int W_REM = (W_SH > W_D2 + W_T) ? W_SH : W_D2 + W_T;

    logic [W_NUM-1:0] w_abs;
    logic             r_neg_a;
    logic [W_MAG-1:0] r_mag_a;
    logic [W_D2-1:0]  r_den_a;
    logic [W_REM-1:0] w_sh;

    logic [W_REM-1:0] r_rem [W_T+1];
    logic [W_T-1:0]   r_q   [W_T+1];
    logic             r_neg [W_T+1];
    logic             r_sat [W_T+1];
    logic [W_D2-1:0]  r_den [W_T+1];

    logic signed [W_T-1:0] r_t;

    assign w_abs = i_num[W_NUM-1] ? W_NUM'(-i_num) : W_NUM'(i_num);
    assign w_sh  = W_REM'(r_mag_a) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a  <= i_num[W_NUM-1];
            r_mag_a  <= w_abs[W_MAG-1:0];
            r_den_a  <= i_den;
            r_rem[0] <= w_sh;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg_a;
            r_sat[0] <= (w_sh >= (W_REM'(r_den_a) << W_T));
            r_den[0] <= r_den_a;
        end
    end

    for (genvar k = 0; k < W_T; k++) begin : g_step
        localparam int J = W_T - 1 - k;
        logic [W_REM-1:0] w_trial;
        logic             w_take;

        assign w_trial = W_REM'(r_den[k]) << J;
        assign w_take  = (r_rem[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_take ? r_rem[k] - w_trial : r_rem[k];
                r_q[k+1]   <= w_take ? r_q[k] | (W_T'(1) << J) : r_q[k];
                r_neg[k+1] <= r_neg[k];
                r_sat[k+1] <= r_sat[k];
                r_den[k+1] <= r_den[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[W_T]) begin
                r_t <= (r_sat[W_T] || (r_q[W_T] > T_MIN)) ? T_MIN : -r_q[W_T];
            end else begin
                r_t <= (r_sat[W_T] || r_q[W_T][W_T-1]) ? T_MAX : r_q[W_T];
            end
        end
    end

    assign o_t = r_t;

endmodule

>>> rtl/rsi_back.sv
// Back pipeline: square root, root division, hit flags and output buffer
`timescale 1ns / 1ps
module rsi_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rsi_pkg::t_front_item           i_item,
    input  rsi_pkg::t_q_stat               i_q_stat,
    output logic                           o_pop,
    input  logic [rsi_pkg::W_MIN-1:0]      i_min_distance,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit,
    output logic signed [rsi_pkg::W_T-1:0] o_first_t,
    output logic                           o_near_valid,
    output logic signed [rsi_pkg::W_T-1:0] o_near_t,
    output logic                           o_far_valid,
    output logic signed [rsi_pkg::W_T-1:0] o_far_t
);
    import rsi_pkg::*;

    localparam logic [1:0] OBUF_FULL = 2'd2;

    logic w_adv;
    logic w_pop;

    logic                    r_sv   [W_ROOT+1];
    logic                    r_sh   [W_ROOT+1];
    logic [W_DELTA-1:0]      r_srem [W_ROOT+1];
    logic [W_ROOT-1:0]       r_root [W_ROOT+1];
    logic signed [W_NUM-1:0] r_sna  [W_ROOT+1];
    logic [W_D2-1:0]         r_sd2  [W_ROOT+1];

    logic                    r_nv;
    logic                    r_nh;
    logic signed [W_NUM-1:0] r_nn;
    logic signed [W_NUM-1:0] r_nf;
    logic [W_D2-1:0]         r_nd2;

    logic r_dv [DIV_LAT];
    logic r_dh [DIV_LAT];

    logic signed [W_T-1:0] w_near_t;
    logic signed [W_T-1:0] w_far_t;
    logic signed [W_T-1:0] w_min;
    t_result               w_res;

    logic [1:0] r_ocnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       w_opush;
    logic       w_opop;

    assign w_adv = (r_ocnt != OBUF_FULL);
    assign w_pop = w_adv && !i_q_stat.empty;
    assign o_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sh[0]   <= i_item.hit;
            r_srem[0] <= i_item.delta;
            r_root[0] <= '0;
            r_sna[0]  <= i_item.neg_a;
            r_sd2[0]  <= i_item.d2;
        end
    end

    for (genvar k = 0; k < W_ROOT; k++) begin : g_sqrt
        localparam int J = W_ROOT - 1 - k;
        logic [W_DELTA-1:0] w_trial;
        logic               w_take;

        assign w_trial = (W_DELTA'(r_root[k]) << (J + 1)) | (W_DELTA'(1) << (2 * J));
        assign w_take  = (r_srem[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sh[k+1]   <= r_sh[k];
                r_srem[k+1] <= w_take ? r_srem[k] - w_trial : r_srem[k];
                r_root[k+1] <= w_take ? r_root[k] | (W_ROOT'(1) << J) : r_root[k];
                r_sna[k+1]  <= r_sna[k];
                r_sd2[k+1]  <= r_sd2[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_nv    <= r_sv[W_ROOT];
            r_dv[0] <= r_nv;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nh    <= r_sh[W_ROOT];
            r_nn    <= r_sna[W_ROOT] - {{(W_NUM-W_ROOT){1'b0}}, r_root[W_ROOT]};
            r_nf    <= r_sna[W_ROOT] + {{(W_NUM-W_ROOT){1'b0}}, r_root[W_ROOT]};
            r_nd2   <= r_sd2[W_ROOT];
            r_dh[0] <= r_nh;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dh[i] <= r_dh[i-1];
            end
        end
    end

    rsi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_near (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_nn),
        .i_den (r_nd2),
        .o_t   (w_near_t)
    );

    rsi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_far (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_nf),
        .i_den (r_nd2),
        .o_t   (w_far_t)
    );

    assign w_min = {{(W_T-W_MIN){1'b0}}, i_min_distance};

    always_comb begin
        w_res = '0;
        if (r_dh[DIV_LAT-1]) begin
            w_res.hit        = 1'b1;
            w_res.first_t    = (w_near_t < w_min) ? w_far_t : w_near_t;
            w_res.near_valid = (w_near_t > w_min);
            w_res.near_t     = w_near_t;
            w_res.far_valid  = (w_far_t > w_min);
            w_res.far_t      = w_far_t;
        end
    end

    assign w_opush = w_adv && r_dv[DIV_LAT-1];
    assign w_opop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
        end else begin
            case ({w_opush, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush && ((r_ocnt == 2'd0) || ((r_ocnt == 2'd1) && w_opop))) begin
            r_slot0 <= w_res;
        end else if (w_opop) begin
            r_slot0 <= r_slot1;
        end
        if (w_opush && (r_ocnt == 2'd1) && !w_opop) begin
            r_slot1 <= w_res;
        end
    end

    assign o_valid      = (r_ocnt != 2'd0);
    assign o_hit        = r_slot0.hit;
    assign o_first_t    = r_slot0.first_t;
    assign o_near_valid = r_slot0.near_valid;
    assign o_near_t     = r_slot0.near_t;
    assign o_far_valid  = r_slot0.far_valid;
    assign o_far_t      = r_slot0.far_t;

endmodule

>>> sim/ray_sphere_intersection_tb.sv
// Self-checking testbench for the ray-sphere intersection engine
`timescale 1ns / 1ps
module ray_sphere_intersection_tb;
    import rsi_pkg::*;

    localparam int FRAC = 16;
    localparam int LAT  = 150;

    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_B = 3'd7;

    typedef logic signed [255:0] wide_t;

    class hit_scoreboard;
        logic signed [W_C-1:0] cx, cy, cz;
        logic [W_RAD-1:0]      rad;
        logic [W_MIN-1:0]      min_dist;
        t_result               expected_q[$];
        int                    mismatches;
        int                    rays, results, hits;

        function new();
            cx = '0; cy = '0; cz = '0;
            rad = RADIUS_RESET;
            min_dist = MIN_RESET;
            mismatches = 0; rays = 0; results = 0; hits = 0;
        endfunction

        function void set_reg(logic [W_CFG_IDX-1:0] idx, logic [W_C-1:0] val);
            case (idx)
                CFG_CENTER_X: cx = val;
                CFG_CENTER_Y: cy = val;
                CFG_CENTER_Z: cz = val;
                CFG_RADIUS:   rad = val[W_RAD-1:0];
                CFG_MIN_DIST: min_dist = val[W_MIN-1:0];
                default: ;
            endcase
        endfunction

        function wide_t floor_sqrt(wide_t x);
            logic [255:0] rem, res, bitv, t;
            rem = x;
            res = '0;
            bitv = 256'd1 << 254;
            for (int k = 0; k < 128; k++) begin
                t = res + bitv;
                if (rem >= t) begin
                    rem = rem - t;
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic signed [W_T-1:0] scaled_root(wide_t num, wide_t den);
            logic [255:0] mag, q;
            logic         neg;
            neg = num[255];
            mag = neg ? -num : num;
            mag = mag << FRAC;
            q = mag / den;
            if (neg) begin
                if (q > 256'h8000_0000) return T_MIN;
                return -q[W_T-1:0];
            end
            if (q > 256'h7FFF_FFFF) return T_MAX;
            return q[W_T-1:0];
        endfunction

        function void note_ray(logic signed [W_C-1:0] o[3], logic signed [W_C-1:0] d[3]);
            wide_t   v, dw, a, d2, len2, r2, delta, s;
            wide_t   cen[3];
            t_result r;
            longint  nt, ft, mv;
            cen[0] = wide_t'(cx); cen[1] = wide_t'(cy); cen[2] = wide_t'(cz);
            a = '0; d2 = '0; len2 = '0;
            for (int i = 0; i < 3; i++) begin
                v = wide_t'(o[i]) - cen[i];
                dw = wide_t'(d[i]);
                a += dw * v;
                d2 += dw * dw;
                len2 += v * v;
            end
            r2 = wide_t'({225'd0, rad}) * wide_t'({225'd0, rad});
            delta = a * a - d2 * (len2 - r2);
            r = '0;
            if (d2 != 0 && !delta[255]) begin
                s = floor_sqrt(delta);
                r.hit = 1'b1;
                r.near_t = scaled_root(-a - s, d2);
                r.far_t = scaled_root(-a + s, d2);
                nt = r.near_t;
                ft = r.far_t;
                mv = longint'(min_dist);
                r.first_t = (nt < mv) ? r.far_t : r.near_t;
                r.near_valid = nt > mv;
                r.far_valid = ft > mv;
                hits++;
            end
            expected_q = {expected_q, r};
            rays++;
        endfunction

        function void check(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result item with no ray pending");
                return;
            end
            e = expected_q.pop_front();
            results++;
            if (got.hit !== e.hit || got.first_t !== e.first_t
                    || got.near_valid !== e.near_valid || got.near_t !== e.near_t
                    || got.far_valid !== e.far_valid || got.far_t !== e.far_t) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: item %0d exp hit=%b first=%0d nv=%b near=%0d fv=%b far=%0d",
                             results, e.hit, e.first_t, e.near_valid, e.near_t,
                             e.far_valid, e.far_t,
                             " got hit=%b first=%0d nv=%b near=%0d fv=%b far=%0d",
                             got.hit, got.first_t, got.near_valid, got.near_t,
                             got.far_valid, got.far_t);
            end
        endfunction
    endclass

    logic                   i_clk, i_rst_n;
    logic                   i_valid, o_ready, o_valid, i_ready;
    logic signed [W_C-1:0]  i_origin_x, i_origin_y, i_origin_z;
    logic signed [W_C-1:0]  i_dir_x, i_dir_y, i_dir_z;
    logic                   o_hit, o_near_valid, o_far_valid;
    logic signed [W_T-1:0]  o_first_t, o_near_t, o_far_t;
    logic                   i_cfg_wr_en;
    logic [W_CFG_IDX-1:0]   i_cfg_index;
    logic [W_C-1:0]         i_cfg_wdata;

    hit_scoreboard sb;
    bit            send_idle, recv_idle;
    int            hold_cycles;

    ray_sphere_intersection #(.FRAC_BITS(FRAC)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls plus a requested long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready = 1'b0;
                hold_cycles--;
            end else begin
                i_ready = !(recv_idle && $urandom_range(99) < 12);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check('{o_hit, o_first_t, o_near_valid, o_near_t, o_far_valid, o_far_t});
    end

    task automatic send_ray(logic signed [W_C-1:0] o[3], logic signed [W_C-1:0] d[3]);
        while (send_idle && $urandom_range(99) < 12) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_origin_x = o[0]; i_origin_y = o[1]; i_origin_z = o[2];
        i_dir_x = d[0]; i_dir_y = d[1]; i_dir_z = d[2];
        do @(posedge i_clk); while (!o_ready);
        sb.note_ray(o, d);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (LAT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [W_CFG_IDX-1:0] idx, logic [W_C-1:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic set_sphere(logic [W_C-1:0] x, logic [W_C-1:0] y, logic [W_C-1:0] z,
                              logic [W_C-1:0] r, logic [W_C-1:0] m);
        write_reg(CFG_CENTER_X, x);
        write_reg(CFG_CENTER_Y, y);
        write_reg(CFG_CENTER_Z, z);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_MIN_DIST, m);
    endtask

    task automatic send_random_ray();
        logic signed [W_C-1:0] o[3], d[3];
        logic signed [W_C-1:0] c[3];
        int                    sh;
        c[0] = sb.cx; c[1] = sb.cy; c[2] = sb.cz;
        if ($urandom_range(9) < 2) begin
            for (int i = 0; i < 3; i++) begin
                o[i] = $urandom;
                d[i] = $urandom;
            end
        end else begin
            sh = $urandom_range(31, 6);
            for (int i = 0; i < 3; i++) begin
                o[i] = c[i] + ($signed($urandom) >>> sh);
                d[i] = (c[i] - o[i]) + ($signed($urandom) >>> $urandom_range(31, 10));
                if ($urandom_range(3) == 0) d[i] = d[i] >>> $urandom_range(12);
            end
            if ($urandom_range(19) == 0) d = '{0, 0, 0};
        end
        send_ray(o, d);
    endtask

    task automatic directed_rays();
        logic signed [W_C-1:0] o[3], d[3];
        o = '{32'sh0, 32'sh0, -32'sh50000};   d = '{0, 0, 32'sh10000};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, 32'sh0};        d = '{32'sh10000, 0, 0};
        send_ray(o, d);
        o = '{32'sh30000, 32'sh0, -32'sh50000}; d = '{0, 0, 32'sh10000};
        send_ray(o, d);
        o = '{32'sh10000, 32'sh0, -32'sh50000}; d = '{0, 0, 32'sh10000};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, 32'sh0};        d = '{0, 0, 0};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, -32'sh50000};   d = '{0, 0, 1};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, 32'sh50000};    d = '{0, 0, 32'sh10000};
        send_ray(o, d);
        o = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        d = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_ray(o, d);
        o = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        d = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, 32'sh0};        d = '{32'sh7FFF_FFFF, 0, 0};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, 32'sh0};        d = '{32'sh8000_0000, 0, 0};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, -32'sh7FFF_0000}; d = '{0, 0, 1};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, 42};            d = '{0, 0, 32'sh10000};
        send_ray(o, d);
        o = '{32'sh0, 32'sh0, 32'shFFBE};     d = '{0, 0, -32'sh10000};
        send_ray(o, d);
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z} = '0;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_cycles = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_rays();
        drain();
        set_sphere(32'h0, 32'h0, 32'h0, 32'h10000, 32'h0);
        directed_rays();
        drain();
        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1_0000);
        directed_rays();
        drain();
        write_reg(CFG_SPARE_B, 32'hDEAD_BEEF);
        write_reg(CFG_SPARE_A, 32'h1234_5678);

        // no idling for the first random stretch
        for (int n = 0; n < 200; n++) send_random_ray();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        for (int n = 0; n < 100; n++) send_random_ray();
        hold_cycles = 300;
        for (int n = 0; n < 100; n++) send_random_ray();
        drain();

        set_sphere($urandom, $urandom, $urandom, $urandom, $urandom);
        for (int n = 0; n < 200; n++) send_random_ray();
        drain();
        set_sphere(32'h10_0000, -32'sh20_0000, 32'h5_0000, 32'h0, 32'h42);
        for (int n = 0; n < 100; n++) send_random_ray();
        drain();
        set_sphere($signed($urandom) >>> 4, $signed($urandom) >>> 4, $signed($urandom) >>> 4,
                   $urandom >> 8, $urandom_range(65536));
        for (int n = 0; n < 200; n++) send_random_ray();
        drain();
        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1_FFFF);
        for (int n = 0; n < 150; n++) send_random_ray();
        drain();

        $display("Rays sent: %0d, results checked: %0d, hits: %0d, mismatches: %0d",
                 sb.rays, sb.results, sb.hits, sb.mismatches);
        $display("Covered default, zero, extreme and random sphere settings with stalls.");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_fifo.sv
rtl/rsi_div.sv
rtl/rsi_back.sv
rtl/ray_sphere_intersection.sv
sim/ray_sphere_intersection_tb.sv
